FILE: rtl/isl_pkg.sv
package isl_pkg;

  localparam int CAPACITY = 16;
  localparam int POS_W    = 5;
  localparam int DATA_W   = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  // common width for comparing positions against the fill count
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_READ   = 2'd3
  } isl_cmd_t;

  typedef struct packed {
    isl_cmd_t                   cmd;
    logic [POS_W-1:0]           position;
    logic signed [DATA_W-1:0]   data_in;
  } isl_req_t;

  typedef struct packed {
    logic                       ok;
    logic signed [DATA_W-1:0]   data_out;
    logic [POS_W-1:0]           count;
  } isl_rsp_t;

  // broadcast to every cell; only raised for commands that succeed
  typedef struct packed {
    logic             insert;
    logic             remove;
    logic [CMP_W-1:0] pos;
  } isl_op_t;

endpackage

FILE: rtl/isl_cell.sv
module isl_cell
  import isl_pkg::*;
(
  input  logic                     clk,
  input  logic [IDX_W-1:0]         idx,
  input  isl_op_t                  op,
  input  logic signed [DATA_W-1:0] data_in,
  input  logic signed [DATA_W-1:0] left,
  input  logic signed [DATA_W-1:0] right,
  output logic signed [DATA_W-1:0] value
);

  logic [CMP_W-1:0]         my_pos;
  logic signed [DATA_W-1:0] value_next;

  assign my_pos = CMP_W'(idx);

  always_comb begin
    value_next = value;
    if (op.insert) begin
      if (my_pos > op.pos) begin
        value_next = left;
      end else if (my_pos == op.pos) begin
        value_next = data_in;
      end
    end else if (op.remove) begin
      if (my_pos >= op.pos) begin
        value_next = right;
      end
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

FILE: rtl/indexed_sequence_list.sv
// Ordered list of up to CAPACITY signed 32-bit values held in a row of
// cells, one entry per cell. On an insert or remove the cells at and above
// the position load from a neighbor or the input at the same clock edge, so
// that part of the row shifts at once. A result is registered and shows on
// rsp in the cycle after the request transfer; a new request is taken every
// cycle while the response register is empty or being taken.
// Entries at or above the count hold no defined value and are never read.
module indexed_sequence_list
  import isl_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  isl_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output isl_rsp_t rsp
);

  logic [CNT_W-1:0]         cnt;
  logic [CNT_W-1:0]         cnt_next;
  logic [CMP_W-1:0]         cnt_ext;
  logic [CMP_W-1:0]         pos_ext;
  logic [CMP_W-1:0]         ins_pos;
  logic                     req_fire;
  logic                     full;
  logic                     ok_c;
  logic signed [DATA_W-1:0] rd_c;
  isl_op_t                  op;
  logic signed [DATA_W-1:0] ent [CAPACITY];

  assign req_ready = !rst && (!rsp_valid || rsp_ready);
  assign req_fire  = req_valid && req_ready;
  assign cnt_ext   = CMP_W'(cnt);
  assign pos_ext   = CMP_W'(req.position);
  assign full      = (cnt == CNT_W'(CAPACITY));
  assign ins_pos   = (req.cmd == CMD_APPEND) ? cnt_ext : pos_ext;

  always_comb begin
    ok_c      = 1'b0;
    rd_c      = '0;
    op.insert = 1'b0;
    op.remove = 1'b0;
    op.pos    = ins_pos;
    cnt_next  = cnt;
    unique case (req.cmd)
      CMD_APPEND, CMD_INSERT: begin
        ok_c = !full && (ins_pos <= cnt_ext);
        if (ok_c) begin
          op.insert = req_fire;
          cnt_next  = cnt + CNT_W'(1);
        end
      end
      CMD_REMOVE: begin
        ok_c = pos_ext < cnt_ext;
        if (ok_c) begin
          op.remove = req_fire;
          cnt_next  = cnt - CNT_W'(1);
        end
      end
      CMD_READ: begin
        ok_c = pos_ext < cnt_ext;
        if (ok_c) begin
          rd_c = ent[pos_ext[IDX_W-1:0]];
        end
      end
      default: begin
        ok_c = 1'b0;
      end
    endcase
  end

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    isl_cell u_cell (
      .clk     (clk),
      .idx     (IDX_W'(k)),
      .op      (op),
      .data_in (req.data_in),
      .left    ((k == 0) ? req.data_in : ent[(k == 0) ? 0 : k - 1]),
      .right   (ent[(k == CAPACITY - 1) ? k : k + 1]),
      .value   (ent[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (req_fire) begin
        cnt       <= cnt_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
    if (req_fire) begin
      rsp.ok       <= ok_c;
      rsp.data_out <= rd_c;
      rsp.count    <= POS_W'(cnt_next);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_reject_hold: assert property (@(posedge clk) disable iff (rst)
    req_fire && !ok_c |=> cnt == $past(cnt))
    else $error("rejected command changed the count");

  a_insert_grow: assert property (@(posedge clk) disable iff (rst)
    req_fire && ok_c && (req.cmd == CMD_APPEND || req.cmd == CMD_INSERT)
    |=> cnt == $past(cnt) + CNT_W'(1))
    else $error("successful insert did not grow the count");

  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> req_ready)
    else $error("not ready with empty response register");

endmodule
